>>> src/queue_shortest_path_engine_assert.svh
// Assertion macros for the shortest path engine.
// They compile to nothing when SYNTHESIS is defined.
`ifndef QUEUE_SHORTEST_PATH_ENGINE_ASSERT_SVH
`define QUEUE_SHORTEST_PATH_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
// check a property on every clock edge, skipped while in reset
`define QSPE_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("qspe assertion failed");
// check a property on every clock edge, reset included
`define QSPE_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("qspe assertion failed");
`else
`define QSPE_ASSERT(lbl, prop)
`define QSPE_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> src/qspe_pkg.sv
// ----------------------------------------------------------------------------
// qspe_pkg
// Types and constants shared by the shortest path engine modules.
// ----------------------------------------------------------------------------
`default_nettype none
package qspe_pkg;

   localparam int MAX_NODES  = 1024;
   localparam int NODE_BITS  = 10;
   localparam int MAX_EDGES  = 4096;
   localparam int EDGE_BITS  = 12;
   localparam int LINK_BITS  = 13;
   localparam int CNT_BITS   = 11;
   localparam int DIST_BITS  = 32;
   localparam int WEIGHT_BITS = 16;

   localparam logic [LINK_BITS-1:0] LIST_EMPTY       = 13'd4096;
   localparam logic [CNT_BITS-1:0]  NODE_COUNT_RESET = 11'd1024;
   localparam logic [CNT_BITS-1:0]  NODE_LIMIT       = 11'd1024;
   localparam logic [DIST_BITS-1:0] INF_DIST         = 32'h3f3f3f3f;
   localparam logic [NODE_BITS-1:0] SWEEP_LAST       = 10'd1023;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_ADD   = 2'd1,
      OP_RUN   = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NEG_CYC  = 2'd1,
      ST_FULL     = 2'd2,
      ST_RANGE    = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      S_INIT_SWEEP,
      S_IDLE,
      S_CLR_SWEEP,
      S_RUN_SWEEP,
      S_RUN_SEED,
      S_POP,
      S_POP_W,
      S_U,
      S_EDGE,
      S_EDGE_W,
      S_RELAX,
      S_ADD,
      S_ADD_W,
      S_ADD_LINK,
      S_READ,
      S_READ_W,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [CNT_BITS-1:0]         tally;
      logic                        queued;
      logic                        reached;
      logic signed [DIST_BITS-1:0] dist_val;
   } node_type;

   typedef struct packed {
      logic [LINK_BITS-1:0] first;
      logic [LINK_BITS-1:0] last;
   } list_type;

   typedef struct packed {
      logic [NODE_BITS-1:0]          target;
      logic signed [WEIGHT_BITS-1:0] cost;
   } edge_type;

endpackage
`default_nettype wire

>>> src/qspe_relax_unit.sv
// ----------------------------------------------------------------------------
// qspe_relax_unit
// Shared adder: candidate distance = node distance + edge cost, saturated
// to the signed 32-bit range.
// ----------------------------------------------------------------------------
`default_nettype none
module qspe_relax_unit (
   input  wire logic signed [qspe_pkg::DIST_BITS-1:0]   dist_u,
   input  wire logic signed [qspe_pkg::WEIGHT_BITS-1:0] cost,
   output logic signed [qspe_pkg::DIST_BITS-1:0]        cand
);
   logic signed [qspe_pkg::DIST_BITS:0] sum;

   always_comb begin
      sum = {dist_u[qspe_pkg::DIST_BITS-1], dist_u}
          + {{(qspe_pkg::DIST_BITS + 1 - qspe_pkg::WEIGHT_BITS)
              {cost[qspe_pkg::WEIGHT_BITS-1]}}, cost};
      // clamp when the top two bits disagree
      if (sum[qspe_pkg::DIST_BITS] != sum[qspe_pkg::DIST_BITS-1]) begin
         cand = sum[qspe_pkg::DIST_BITS] ? {1'b1, {(qspe_pkg::DIST_BITS-1){1'b0}}}
                                         : {1'b0, {(qspe_pkg::DIST_BITS-1){1'b1}}};
      end else begin
         cand = sum[qspe_pkg::DIST_BITS-1:0];
      end
   end
endmodule
`default_nettype wire

>>> src/queue_shortest_path_engine.sv
// ----------------------------------------------------------------------------
// queue_shortest_path_engine
// Queued Bellman-Ford shortest path engine with negative cycle detection.
// ----------------------------------------------------------------------------
// One item at a time. After reset the engine sweeps its list and node memories
// before it takes the first item. A clear graph item sweeps the list memory,
// an add edge item appends to the source node's edge list, a read item reads
// the node memory, and an out-of-range item goes straight to its result. A run
// sweeps the node memory, seeds the source, then dequeues nodes and relaxes
// each one's edges, all through one sequencer and one shared adder over
// one-read one-write memories. The result waits in an output register; the
// next item can be taken while it is stalled.
`default_nettype none
`include "queue_shortest_path_engine_assert.svh"
module queue_shortest_path_engine (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_wr_en,
   input  wire logic [qspe_pkg::CNT_BITS-1:0]      csr_wr_data,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [1:0]                         req_type,
   input  wire logic [qspe_pkg::NODE_BITS-1:0]     req_from_node,
   input  wire logic [qspe_pkg::NODE_BITS-1:0]     req_to_node,
   input  wire logic signed [qspe_pkg::WEIGHT_BITS-1:0] req_edge_weight,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [1:0]                              rsp_status,
   output logic signed [qspe_pkg::DIST_BITS-1:0]   rsp_distance,
   output logic                                    rsp_reachable
);
   localparam int NB = qspe_pkg::NODE_BITS;
   localparam int EB = qspe_pkg::EDGE_BITS;
   localparam int LB = qspe_pkg::LINK_BITS;
   localparam int CB = qspe_pkg::CNT_BITS;
   localparam int DB = qspe_pkg::DIST_BITS;
   localparam int WB = qspe_pkg::WEIGHT_BITS;

   // memories
   qspe_pkg::node_type node_mem [0:qspe_pkg::MAX_NODES-1];
   qspe_pkg::list_type list_mem [0:qspe_pkg::MAX_NODES-1];
   qspe_pkg::edge_type edge_mem [0:qspe_pkg::MAX_EDGES-1];
   logic [LB-1:0]      link_mem [0:qspe_pkg::MAX_EDGES-1];
   logic [NB-1:0]      ring_mem [0:qspe_pkg::MAX_NODES-1];

   qspe_pkg::node_type node_q;
   qspe_pkg::list_type list_q;
   qspe_pkg::edge_type edge_q;
   logic [LB-1:0]      link_q;
   logic [NB-1:0]      ring_q;

   logic [NB-1:0]      node_raddr, node_waddr, list_raddr, list_waddr;
   logic [NB-1:0]      ring_raddr;
   logic [EB-1:0]      edge_raddr, edge_waddr, link_waddr;
   logic               node_we, list_we, edge_we, link_we, ring_we;
   qspe_pkg::node_type node_wdata;
   qspe_pkg::list_type list_wdata;
   qspe_pkg::edge_type edge_wdata;
   logic [LB-1:0]      link_wdata;
   logic [NB-1:0]      ring_wdata;

   // registers
   qspe_pkg::state_type  state_ff, state_in;
   qspe_pkg::status_type status_ff, status_in;
   logic [CB-1:0]   node_count_ff;
   logic [NB-1:0]   sweep_ff, sweep_in;
   logic [NB-1:0]   a_ff, a_in, b_ff, b_in;
   logic signed [WB-1:0] w_ff, w_in;
   logic [LB-1:0]   edges_used_ff, edges_used_in;
   logic [NB-1:0]   ring_rd_ff, ring_rd_in, ring_wr_ff, ring_wr_in;
   logic [CB-1:0]   ring_fill_ff, ring_fill_in;
   logic [NB-1:0]   u_ff, u_in, v_ff, v_in;
   logic signed [DB-1:0] dist_u_ff, dist_u_in, cand_ff, cand_in;
   logic [LB-1:0]   e_ff, e_in, link_ff, link_in;
   logic signed [DB-1:0] res_dist_ff, res_dist_in;
   logic            res_reach_ff, res_reach_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [1:0]      rsp_status_ff, rsp_status_in;
   logic signed [DB-1:0] rsp_dist_ff, rsp_dist_in;
   logic            rsp_reach_ff, rsp_reach_in;

   logic [CB-1:0]   n_eff;
   logic signed [DB-1:0] cand_w;
   logic [CB-1:0]   tally_next;
   logic            push_w;

   assign n_eff = (node_count_ff > qspe_pkg::NODE_LIMIT) ? qspe_pkg::NODE_LIMIT
                                                         : node_count_ff;

   qspe_relax_unit u_relax (
      .dist_u (dist_u_ff),
      .cost   (edge_q.cost),
      .cand   (cand_w)
   );

   // memory ports
   always_ff @(posedge clock) begin
      node_q <= node_mem[node_raddr];
      if (node_we) node_mem[node_waddr] <= node_wdata;
   end
   always_ff @(posedge clock) begin
      list_q <= list_mem[list_raddr];
      if (list_we) list_mem[list_waddr] <= list_wdata;
   end
   always_ff @(posedge clock) begin
      edge_q <= edge_mem[edge_raddr];
      if (edge_we) edge_mem[edge_waddr] <= edge_wdata;
   end
   always_ff @(posedge clock) begin
      link_q <= link_mem[edge_raddr];
      if (link_we) link_mem[link_waddr] <= link_wdata;
   end
   always_ff @(posedge clock) begin
      ring_q <= ring_mem[ring_raddr];
      if (ring_we) ring_mem[ring_wr_ff] <= ring_wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= qspe_pkg::S_INIT_SWEEP;
         node_count_ff <= qspe_pkg::NODE_COUNT_RESET;
         sweep_ff      <= '0;
         edges_used_ff <= '0;
         ring_rd_ff    <= '0;
         ring_wr_ff    <= '0;
         ring_fill_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         if (csr_wr_en) node_count_ff <= csr_wr_data;
         sweep_ff      <= sweep_in;
         edges_used_ff <= edges_used_in;
         ring_rd_ff    <= ring_rd_in;
         ring_wr_ff    <= ring_wr_in;
         ring_fill_ff  <= ring_fill_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff     <= status_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      w_ff          <= w_in;
      u_ff          <= u_in;
      v_ff          <= v_in;
      dist_u_ff     <= dist_u_in;
      cand_ff       <= cand_in;
      e_ff          <= e_in;
      link_ff       <= link_in;
      res_dist_ff   <= res_dist_in;
      res_reach_ff  <= res_reach_in;
      rsp_status_ff <= rsp_status_in;
      rsp_dist_ff   <= rsp_dist_in;
      rsp_reach_ff  <= rsp_reach_in;
   end

   always_comb begin
      state_in      = state_ff;
      status_in     = status_ff;
      sweep_in      = sweep_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      w_in          = w_ff;
      edges_used_in = edges_used_ff;
      ring_rd_in    = ring_rd_ff;
      ring_wr_in    = ring_wr_ff;
      ring_fill_in  = ring_fill_ff;
      u_in          = u_ff;
      v_in          = v_ff;
      dist_u_in     = dist_u_ff;
      cand_in       = cand_ff;
      e_in          = e_ff;
      link_in       = link_ff;
      res_dist_in   = res_dist_ff;
      res_reach_in  = res_reach_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_reach_in  = rsp_reach_ff;

      node_raddr = a_ff;
      node_we    = 1'b0;
      node_waddr = sweep_ff;
      node_wdata = '{tally: '0, queued: 1'b0, reached: 1'b0, dist_val: qspe_pkg::INF_DIST};
      list_raddr = a_ff;
      list_we    = 1'b0;
      list_waddr = sweep_ff;
      list_wdata = '{first: qspe_pkg::LIST_EMPTY, last: '0};
      edge_raddr = e_ff[EB-1:0];
      edge_we    = 1'b0;
      edge_waddr = edges_used_ff[EB-1:0];
      edge_wdata = '{target: b_ff, cost: w_ff};
      link_we    = 1'b0;
      link_waddr = edges_used_ff[EB-1:0];
      link_wdata = qspe_pkg::LIST_EMPTY;
      ring_raddr = ring_rd_ff;
      ring_we    = 1'b0;
      ring_wdata = a_ff;
      tally_next = node_q.tally + 1'b1;
      push_w     = 1'b0;
      req_stall  = 1'b1;

      unique case (state_ff)
         qspe_pkg::S_INIT_SWEEP: begin
            node_we  = 1'b1;
            list_we  = 1'b1;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == qspe_pkg::SWEEP_LAST) state_in = qspe_pkg::S_IDLE;
         end
         qspe_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               a_in         = req_from_node;
               b_in         = req_to_node;
               w_in         = req_edge_weight;
               sweep_in     = '0;
               status_in    = qspe_pkg::ST_OK;
               res_dist_in  = '0;
               res_reach_in = 1'b0;
               unique case (qspe_pkg::op_type'(req_type))
                  qspe_pkg::OP_CLEAR: state_in = qspe_pkg::S_CLR_SWEEP;
                  qspe_pkg::OP_ADD: begin
                     if ({1'b0, req_from_node} >= n_eff || {1'b0, req_to_node} >= n_eff) begin
                        status_in = qspe_pkg::ST_RANGE;
                        state_in  = qspe_pkg::S_DONE;
                     end else if (edges_used_ff[EB]) begin
                        status_in = qspe_pkg::ST_FULL;
                        state_in  = qspe_pkg::S_DONE;
                     end else begin
                        state_in  = qspe_pkg::S_ADD;
                     end
                  end
                  qspe_pkg::OP_RUN: begin
                     if ({1'b0, req_from_node} >= n_eff) begin
                        status_in = qspe_pkg::ST_RANGE;
                        state_in  = qspe_pkg::S_DONE;
                     end else begin
                        state_in  = qspe_pkg::S_RUN_SWEEP;
                     end
                  end
                  qspe_pkg::OP_READ: begin
                     if ({1'b0, req_from_node} >= n_eff) begin
                        status_in = qspe_pkg::ST_RANGE;
                        state_in  = qspe_pkg::S_DONE;
                     end else begin
                        state_in  = qspe_pkg::S_READ;
                     end
                  end
                  default: state_in = qspe_pkg::S_DONE;
               endcase
            end
         end
         qspe_pkg::S_CLR_SWEEP: begin
            list_we  = 1'b1;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == qspe_pkg::SWEEP_LAST) begin
               edges_used_in = '0;
               state_in      = qspe_pkg::S_DONE;
            end
         end
         qspe_pkg::S_RUN_SWEEP: begin
            node_we      = 1'b1;
            sweep_in     = sweep_ff + 1'b1;
            ring_rd_in   = '0;
            ring_wr_in   = '0;
            ring_fill_in = '0;
            if (sweep_ff == qspe_pkg::SWEEP_LAST) state_in = qspe_pkg::S_RUN_SEED;
         end
         qspe_pkg::S_RUN_SEED: begin
            node_we      = 1'b1;
            node_waddr   = a_ff;
            node_wdata   = '{tally: CB'(1), queued: 1'b1, reached: 1'b1, dist_val: '0};
            ring_we      = 1'b1;
            ring_wdata   = a_ff;
            ring_wr_in   = ring_wr_ff + 1'b1;
            ring_fill_in = ring_fill_ff + 1'b1;
            state_in     = qspe_pkg::S_POP;
         end
         qspe_pkg::S_POP: begin
            if (ring_fill_ff == '0) begin
               state_in = qspe_pkg::S_DONE;
            end else begin
               ring_rd_in   = ring_rd_ff + 1'b1;
               ring_fill_in = ring_fill_ff - 1'b1;
               state_in     = qspe_pkg::S_POP_W;
            end
         end
         qspe_pkg::S_POP_W: begin
            u_in       = ring_q;
            node_raddr = ring_q;
            list_raddr = ring_q;
            state_in   = qspe_pkg::S_U;
         end
         qspe_pkg::S_U: begin
            dist_u_in  = node_q.dist_val;
            e_in       = list_q.first;
            node_we    = 1'b1;
            node_waddr = u_ff;
            node_wdata = node_q;
            node_wdata.queued = 1'b0;
            state_in   = qspe_pkg::S_EDGE;
         end
         qspe_pkg::S_EDGE: begin
            // any link with bit 12 set (4096 or more) ends the list
            if (e_ff[EB]) state_in = qspe_pkg::S_POP;
            else          state_in = qspe_pkg::S_EDGE_W;
         end
         qspe_pkg::S_EDGE_W: begin
            v_in       = edge_q.target;
            link_in    = link_q;
            cand_in    = cand_w;
            node_raddr = edge_q.target;
            state_in   = qspe_pkg::S_RELAX;
         end
         qspe_pkg::S_RELAX: begin
            e_in     = link_ff;
            state_in = qspe_pkg::S_EDGE;
            if (!node_q.reached || node_q.dist_val > cand_ff) begin
               node_we    = 1'b1;
               node_waddr = v_ff;
               node_wdata = node_q;
               node_wdata.dist_val = cand_ff;
               node_wdata.reached  = 1'b1;
               // keep the dequeued node's distance current on a self edge
               if (v_ff == u_ff) dist_u_in = cand_ff;
               if (!node_q.queued) begin
                  node_wdata.queued = 1'b1;
                  node_wdata.tally  = tally_next;
                  if (ring_fill_ff < qspe_pkg::NODE_LIMIT) begin
                     push_w       = 1'b1;
                     ring_we      = 1'b1;
                     ring_wdata   = v_ff;
                     ring_wr_in   = ring_wr_ff + 1'b1;
                     ring_fill_in = ring_fill_ff + 1'b1;
                  end
                  if (tally_next > n_eff) begin
                     status_in = qspe_pkg::ST_NEG_CYC;
                     state_in  = qspe_pkg::S_DONE;
                  end
               end
            end
         end
         qspe_pkg::S_ADD: begin
            state_in = qspe_pkg::S_ADD_W;
         end
         qspe_pkg::S_ADD_W: begin
            edge_we       = 1'b1;
            link_we       = 1'b1;
            list_we       = 1'b1;
            list_waddr    = a_ff;
            e_in          = edges_used_ff;
            edges_used_in = edges_used_ff + 1'b1;
            if (list_q.first[EB]) begin
               list_wdata = '{first: edges_used_ff, last: edges_used_ff};
               state_in   = qspe_pkg::S_DONE;
            end else begin
               list_wdata = '{first: list_q.first, last: edges_used_ff};
               link_in    = list_q.last;
               state_in   = qspe_pkg::S_ADD_LINK;
            end
         end
         qspe_pkg::S_ADD_LINK: begin
            // chain the new edge behind the old tail
            link_we    = 1'b1;
            link_waddr = link_ff[EB-1:0];
            link_wdata = e_ff;
            state_in   = qspe_pkg::S_DONE;
         end
         qspe_pkg::S_READ: begin
            state_in = qspe_pkg::S_READ_W;
         end
         qspe_pkg::S_READ_W: begin
            if (node_q.reached) begin
               res_dist_in  = node_q.dist_val;
               res_reach_in = 1'b1;
            end
            state_in = qspe_pkg::S_DONE;
         end
         qspe_pkg::S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_dist_in   = res_dist_ff;
               rsp_reach_in  = res_reach_ff;
               state_in      = qspe_pkg::S_IDLE;
            end
         end
         default: state_in = qspe_pkg::S_IDLE;
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_distance  = rsp_dist_ff;
   assign rsp_reachable = rsp_reach_ff;

   `QSPE_ASSERT(a_ring_bound, ring_fill_ff <= qspe_pkg::NODE_LIMIT)
   `QSPE_ASSERT(a_edges_bound, edges_used_ff <= qspe_pkg::LIST_EMPTY)
   `QSPE_ASSERT(a_push_room, push_w |-> ring_fill_ff < qspe_pkg::NODE_LIMIT)
   `QSPE_ASSERT(a_accept_leaves_idle, (req_valid && !req_stall) |=> state_ff != qspe_pkg::S_IDLE)
   `QSPE_ASSERT_ALWAYS(a_no_take_in_sweep, reset || state_ff != qspe_pkg::S_INIT_SWEEP || req_stall)

endmodule
`default_nettype wire

>>> dv/tb_queue_shortest_path_engine.sv
// ----------------------------------------------------------------------------
// tb_queue_shortest_path_engine
// Self-checking bench for the shortest path engine. A short table of directed
// items and then random graph traffic under several node counts. Every result
// is checked against an in-bench path solver or an expected result in the
// table, while requests idle and the response side stalls in random bursts.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_queue_shortest_path_engine;
   localparam int WB = qspe_pkg::WEIGHT_BITS;
   localparam int LB = qspe_pkg::LINK_BITS;

   typedef struct {
      qspe_pkg::status_type                  status;
      logic signed [qspe_pkg::DIST_BITS-1:0] distance;
      logic                                  reachable;
   } result_type;

   typedef struct {
      bit                                  is_cfg;
      qspe_pkg::op_type                    op;
      logic [qspe_pkg::NODE_BITS-1:0]      from_node;
      logic [qspe_pkg::NODE_BITS-1:0]      to_node;
      logic signed [WB-1:0]                weight;
      int                                  repeats;
      bit                                  typed;
      result_type                          res;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [qspe_pkg::CNT_BITS-1:0] csr_wr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_type = qspe_pkg::OP_CLEAR;
   logic [qspe_pkg::NODE_BITS-1:0] req_from_node = '0;
   logic [qspe_pkg::NODE_BITS-1:0] req_to_node = '0;
   logic signed [WB-1:0] req_edge_weight = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic signed [qspe_pkg::DIST_BITS-1:0] rsp_distance;
   logic rsp_reachable;

   queue_shortest_path_engine uut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
      .req_from_node(req_from_node), .req_to_node(req_to_node),
      .req_edge_weight(req_edge_weight),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_distance(rsp_distance), .rsp_reachable(rsp_reachable)
   );

   always #5 clock = ~clock;

   // solver state
   logic [qspe_pkg::CNT_BITS-1:0]         node_limit_reg;
   logic [qspe_pkg::NODE_BITS-1:0]        edge_to [qspe_pkg::MAX_EDGES];
   logic signed [WB-1:0]                  edge_wt [qspe_pkg::MAX_EDGES];
   logic [LB-1:0]                         edge_next [qspe_pkg::MAX_EDGES];
   logic [LB-1:0]                         head [qspe_pkg::MAX_NODES];
   logic [LB-1:0]                         tail [qspe_pkg::MAX_NODES];
   int                                    edge_total;
   logic signed [qspe_pkg::DIST_BITS-1:0] node_dist [qspe_pkg::MAX_NODES];
   bit                                    seen [qspe_pkg::MAX_NODES];
   bit                                    in_queue [qspe_pkg::MAX_NODES];
   int                                    pushes [qspe_pkg::MAX_NODES];

   result_type pending_results[$];
   row_type    stim_table[$];
   int errors = 0;
   int items_sent = 0;
   int results_seen = 0;
   int neg_cycles = 0;
   bit quiet = 1'b0;
   int hold = 0;

   function automatic int active_nodes();
      return (node_limit_reg > qspe_pkg::MAX_NODES) ? qspe_pkg::MAX_NODES
                                                    : int'(node_limit_reg);
   endfunction

   function automatic void clear_lists();
      foreach (head[i]) head[i] = qspe_pkg::LIST_EMPTY;
      edge_total = 0;
   endfunction

   // queued Bellman-Ford; returns 1 on a negative cycle
   function automatic bit solve_from(int src, int n);
      int ring[$];
      int u, v;
      int e;
      longint cand;
      foreach (node_dist[i]) begin
         node_dist[i] = qspe_pkg::INF_DIST;
         seen[i] = 0;
         in_queue[i] = 0;
         pushes[i] = 0;
      end
      node_dist[src] = 0;
      seen[src] = 1;
      in_queue[src] = 1;
      pushes[src] = 1;
      ring.insert(ring.size(), src);
      while (ring.size() > 0) begin
         u = ring.pop_front();
         in_queue[u] = 0;
         e = int'(head[u]);
         while (e < qspe_pkg::MAX_EDGES) begin
            v = int'(edge_to[e]);
            cand = longint'(node_dist[u]) + longint'(edge_wt[e]);
            if (cand > 64'sd2147483647) cand = 64'sd2147483647;
            if (cand < -64'sd2147483648) cand = -64'sd2147483648;
            if (!seen[v] || longint'(node_dist[v]) > cand) begin
               node_dist[v] = cand[31:0];
               seen[v] = 1;
               if (!in_queue[v]) begin
                  in_queue[v] = 1;
                  if (ring.size() < qspe_pkg::MAX_NODES) ring.insert(ring.size(), v);
                  pushes[v]++;
                  if (pushes[v] > n) return 1;
               end
            end
            e = int'(edge_next[e]);
         end
      end
      return 0;
   endfunction

   function automatic result_type predict_path(qspe_pkg::op_type op, int a, int b,
                                               logic signed [WB-1:0] w);
      result_type r;
      int n;
      n = active_nodes();
      r.status = qspe_pkg::ST_OK;
      r.distance = 0;
      r.reachable = 0;
      case (op)
         qspe_pkg::OP_CLEAR: clear_lists();
         qspe_pkg::OP_ADD: begin
            if (a >= n || b >= n) r.status = qspe_pkg::ST_RANGE;
            else if (edge_total >= qspe_pkg::MAX_EDGES) r.status = qspe_pkg::ST_FULL;
            else begin
               edge_to[edge_total] = b[qspe_pkg::NODE_BITS-1:0];
               edge_wt[edge_total] = w;
               edge_next[edge_total] = qspe_pkg::LIST_EMPTY;
               if (head[a] == qspe_pkg::LIST_EMPTY) head[a] = LB'(edge_total);
               else edge_next[tail[a][qspe_pkg::EDGE_BITS-1:0]] = LB'(edge_total);
               tail[a] = LB'(edge_total);
               edge_total++;
            end
         end
         qspe_pkg::OP_RUN: begin
            if (a >= n) r.status = qspe_pkg::ST_RANGE;
            else if (solve_from(a, n)) r.status = qspe_pkg::ST_NEG_CYC;
         end
         default: begin
            if (a >= n) r.status = qspe_pkg::ST_RANGE;
            else if (seen[a]) begin
               r.distance = node_dist[a];
               r.reachable = 1;
            end
         end
      endcase
      return r;
   endfunction

   // called at a rising edge; returns at the edge that accepts the item
   task automatic send_item(qspe_pkg::op_type op, int a, int b,
                            logic signed [WB-1:0] w, bit typed,
                            result_type typed_res);
      int gap;
      result_type r;
      gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 19) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_type <= op;
      req_from_node <= a[qspe_pkg::NODE_BITS-1:0];
      req_to_node <= b[qspe_pkg::NODE_BITS-1:0];
      req_edge_weight <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      r = predict_path(op, a, b, w);
      if (op == qspe_pkg::OP_RUN && r.status == qspe_pkg::ST_NEG_CYC) neg_cycles++;
      if (typed) r = typed_res;
      pending_results.insert(pending_results.size(), r);
      items_sent++;
   endtask

   task automatic write_node_count(int value);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value[qspe_pkg::CNT_BITS-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      node_limit_reg = value[qspe_pkg::CNT_BITS-1:0];
   endtask

   task automatic add_row(bit is_cfg, qspe_pkg::op_type op, int a, int b, int w,
                          int reps, bit typed, qspe_pkg::status_type st, int d, bit r);
      row_type row;
      row.is_cfg = is_cfg;
      row.op = op;
      row.from_node = a[qspe_pkg::NODE_BITS-1:0];
      row.to_node = b[qspe_pkg::NODE_BITS-1:0];
      row.weight = w[WB-1:0];
      row.repeats = reps;
      row.typed = typed;
      row.res.status = st;
      row.res.distance = d;
      row.res.reachable = r;
      stim_table.insert(stim_table.size(), row);
   endtask

   // response side stalls in bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold > 0) begin
         hold <= hold - 1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         rsp_stall <= 1'b1;
         hold <= $urandom_range(0, 18);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            $error("unexpected result: status %0d distance %0d", rsp_status, rsp_distance);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_status);
               errors++;
            end
            if (rsp_distance !== want.distance) begin
               $error("distance: expected %0d, actual %0d", want.distance, rsp_distance);
               errors++;
            end
            if (rsp_reachable !== want.reachable) begin
               $error("reachable: expected %0d, actual %0d", want.reachable,
                      rsp_reachable);
               errors++;
            end
         end
      end
   end

   initial begin
      #1_000_000_000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      int node_settings[6] = '{1024, 16, 2047, 1, 5, 8};
      int n, span, a, b, pick;
      qspe_pkg::op_type op;
      logic signed [WB-1:0] w;
      result_type none;
      none.status = qspe_pkg::ST_OK;
      none.distance = 0;
      none.reachable = 0;

      node_limit_reg = qspe_pkg::NODE_COUNT_RESET;
      clear_lists();
      foreach (node_dist[i]) begin
         node_dist[i] = qspe_pkg::INF_DIST;
         seen[i] = 0;
      end

      // directed items
      add_row(0, qspe_pkg::OP_READ, 5, 0, 0, 1, 1, qspe_pkg::ST_OK, 0, 0);
      add_row(0, qspe_pkg::OP_RUN, 3, 0, 0, 1, 1, qspe_pkg::ST_OK, 0, 0);
      add_row(0, qspe_pkg::OP_READ, 3, 0, 0, 1, 1, qspe_pkg::ST_OK, 0, 1);
      add_row(0, qspe_pkg::OP_READ, 1023, 0, 0, 1, 1, qspe_pkg::ST_OK, 0, 0);
      add_row(0, qspe_pkg::OP_ADD, 0, 1, 32767, 1, 0, qspe_pkg::ST_OK, 0, 0);
      add_row(0, qspe_pkg::OP_ADD, 1, 2, -32768, 1, 0, qspe_pkg::ST_OK, 0, 0);
      add_row(0, qspe_pkg::OP_ADD, 0, 2, 5, 1, 0, qspe_pkg::ST_OK, 0, 0);
      add_row(0, qspe_pkg::OP_ADD, 2, 1023, -1, 1, 0, qspe_pkg::ST_OK, 0, 0);
      add_row(0, qspe_pkg::OP_RUN, 0, 0, 0, 1, 0, qspe_pkg::ST_OK, 0, 0);
      add_row(0, qspe_pkg::OP_READ, 2, 0, 0, 1, 0, qspe_pkg::ST_OK, 0, 0);
      add_row(0, qspe_pkg::OP_READ, 1023, 0, 0, 1, 0, qspe_pkg::ST_OK, 0, 0);
      add_row(0, qspe_pkg::OP_ADD, 1023, 0, 1, 1, 0, qspe_pkg::ST_OK, 0, 0);
      add_row(0, qspe_pkg::OP_RUN, 0, 0, 0, 1, 0, qspe_pkg::ST_OK, 0, 0);
      add_row(0, qspe_pkg::OP_READ, 1, 0, 0, 1, 0, qspe_pkg::ST_OK, 0, 0);
      add_row(0, qspe_pkg::OP_CLEAR, 0, 0, 0, 1, 0, qspe_pkg::ST_OK, 0, 0);
      add_row(0, qspe_pkg::OP_READ, 2, 0, 0, 1, 0, qspe_pkg::ST_OK, 0, 0);
      add_row(1, qspe_pkg::OP_CLEAR, 16, 0, 0, 1, 0, qspe_pkg::ST_OK, 0, 0);
      add_row(0, qspe_pkg::OP_ADD, 20, 1, 0, 1, 1, qspe_pkg::ST_RANGE, 0, 0);
      add_row(0, qspe_pkg::OP_READ, 16, 0, 0, 1, 1, qspe_pkg::ST_RANGE, 0, 0);
      add_row(0, qspe_pkg::OP_RUN, 0, 0, 0, 1, 0, qspe_pkg::ST_OK, 0, 0);
      add_row(0, qspe_pkg::OP_ADD, 0, 0, 0, 1, 0, qspe_pkg::ST_OK, 0, 0);
      add_row(0, qspe_pkg::OP_ADD, 1, 2, 7, 1, 0, qspe_pkg::ST_OK, 0, 0);
      add_row(0, qspe_pkg::OP_ADD, 3, 17, 0, 1, 1, qspe_pkg::ST_RANGE, 0, 0);
      add_row(0, qspe_pkg::OP_CLEAR, 0, 0, 0, 1, 0, qspe_pkg::ST_OK, 0, 0);
      add_row(1, qspe_pkg::OP_CLEAR, 0, 0, 0, 1, 0, qspe_pkg::ST_OK, 0, 0);
      add_row(0, qspe_pkg::OP_READ, 0, 0, 0, 1, 1, qspe_pkg::ST_RANGE, 0, 0);
      add_row(1, qspe_pkg::OP_CLEAR, 2047, 0, 0, 1, 0, qspe_pkg::ST_OK, 0, 0);
      add_row(0, qspe_pkg::OP_READ, 1023, 0, 0, 1, 1, qspe_pkg::ST_OK, 0, 0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_table[i]) begin
         if (stim_table[i].is_cfg) begin
            write_node_count(stim_table[i].from_node == 0 && stim_table[i].to_node == 0
                             && i == 24 ? 0 : (i == 26 ? 2047 : 16));
         end else begin
            repeat (stim_table[i].repeats)
               send_item(stim_table[i].op, int'(stim_table[i].from_node),
                         int'(stim_table[i].to_node), stim_table[i].weight,
                         stim_table[i].typed, stim_table[i].res);
         end
      end

      // random graph traffic, one node count per phase
      foreach (node_settings[p]) begin
         write_node_count(node_settings[p]);
         if (p == 5) quiet = 1'b1;
         send_item(qspe_pkg::OP_CLEAR, 0, 0, 0, 0, none);
         n = active_nodes();
         span = (n > 16) ? 6 : n;
         repeat (65) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) op = qspe_pkg::OP_CLEAR;
            else if (pick < 50) op = qspe_pkg::OP_ADD;
            else if (pick < 65) op = qspe_pkg::OP_RUN;
            else op = qspe_pkg::OP_READ;
            a = ($urandom_range(0, 13) == 0) ? $urandom_range(0, 1023)
                                              : $urandom_range(0, span - 1);
            b = ($urandom_range(0, 13) == 0) ? $urandom_range(0, 1023)
                                              : $urandom_range(0, span - 1);
            if ($urandom_range(0, 9) < 7) w = WB'($urandom_range(0, 24) - 3);
            else w = WB'($urandom_range(0, 65535));
            send_item(op, a, b, w, 0, none);
         end
      end

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("covered %0d items and %0d results over directed rows and six node count phases,",
               items_sent, results_seen);
      $display("including out-of-range requests and %0d negative cycle runs", neg_cycles);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire

>>> files.f
+incdir+src
src/qspe_pkg.sv
src/qspe_relax_unit.sv
src/queue_shortest_path_engine.sv
dv/tb_queue_shortest_path_engine.sv
